FILE: rtl/core/psa_pkg.sv
// Shared types and constants for the patch stream applier.
// Depends on nothing; used by psa_sequencer and patch_stream_applier.
package psa_pkg;

    localparam int WORD_W      = 32;
    localparam int ADDR_W      = 64;
    localparam int CFG_INDEX_W = 8;

    localparam int SLOT_STRIDE_BYTES = 4096;
    localparam int SLOT_COUNT        = 3;
    localparam int SLOT_WORDS        = SLOT_STRIDE_BYTES / 4;
    localparam int SLOT_IDX_W        = $clog2(SLOT_WORDS);
    localparam int SLOT_NUM_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int REM_OFF_W         = $clog2(SLOT_STRIDE_BYTES * SLOT_COUNT) + 1;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAIN_BASE      = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_REMAINDER_BASE = CFG_INDEX_W'(1);

    localparam logic [ADDR_W-1:0] MAIN_BASE_RESET      = 64'h8000_0000_0000_0000;
    localparam logic [ADDR_W-1:0] REMAINDER_BASE_RESET = 64'h8000_0000_0100_0000;

    typedef enum logic [2:0] {
        PH_OFFSET,
        PH_COUNT,
        PH_DATA,
        PH_REMAINDER,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] data;
        logic              in_remainder;
        logic              stream_done;
    } psa_result_t;

endpackage

FILE: rtl/core/psa_sequencer.sv
// Phase machine of the patch stream applier: record parsing and remainder slots.
// Depends on psa_pkg; instantiated by patch_stream_applier.
module psa_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [psa_pkg::WORD_W-1:0]  word,
    input  logic [psa_pkg::ADDR_W-1:0]  main_base,
    input  logic [psa_pkg::ADDR_W-1:0]  remainder_base,
    output psa_pkg::psa_result_t        result
);

    psa_pkg::phase_t                       phase_reg, phase_next;
    logic [psa_pkg::WORD_W-1:0]            offset_reg, offset_next;
    logic [psa_pkg::WORD_W-1:0]            left_reg, left_next;
    logic [psa_pkg::SLOT_NUM_W-1:0]        slot_reg, slot_next;
    logic [psa_pkg::REM_OFF_W-1:0]         slot_off_reg, slot_off_next;
    logic [psa_pkg::SLOT_IDX_W-1:0]        idx_reg, idx_next;

    logic                                  is_term;
    logic                                  last_slot;
    logic [psa_pkg::REM_OFF_W-1:0]         rem_off;

    assign is_term   = (word == psa_pkg::ALL_ONES);
    assign last_slot = (slot_reg == psa_pkg::SLOT_NUM_W'(psa_pkg::SLOT_COUNT - 1));
    assign rem_off   = slot_off_reg
                     + psa_pkg::REM_OFF_W'({idx_reg, 2'b00});

    always_comb
    begin
        phase_next    = phase_reg;
        offset_next   = offset_reg;
        left_next     = left_reg;
        slot_next     = slot_reg;
        slot_off_next = slot_off_reg;
        idx_next      = idx_reg;
        if (step)
        begin
            unique case (phase_reg)
                psa_pkg::PH_OFFSET:
                begin
                    if (is_term)
                    begin
                        phase_next    = psa_pkg::PH_REMAINDER;
                        slot_next     = '0;
                        slot_off_next = '0;
                        idx_next      = '0;
                    end
                    else
                    begin
                        offset_next = word;
                        phase_next  = psa_pkg::PH_COUNT;
                    end
                end
                psa_pkg::PH_COUNT:
                begin
                    left_next  = word;
                    phase_next = (word == '0) ? psa_pkg::PH_OFFSET : psa_pkg::PH_DATA;
                end
                psa_pkg::PH_DATA:
                begin
                    offset_next = offset_reg + psa_pkg::WORD_W'(4);
                    left_next   = left_reg - psa_pkg::WORD_W'(1);
                    if (left_reg == psa_pkg::WORD_W'(1))
                        phase_next = psa_pkg::PH_OFFSET;
                end
                psa_pkg::PH_REMAINDER:
                begin
                    if (is_term)
                    begin
                        idx_next      = '0;
                        slot_next     = slot_reg + psa_pkg::SLOT_NUM_W'(1);
                        slot_off_next = slot_off_reg
                                      + psa_pkg::REM_OFF_W'(psa_pkg::SLOT_STRIDE_BYTES);
                        if (last_slot)
                            phase_next = psa_pkg::PH_DONE;
                    end
                    else if (idx_reg == psa_pkg::SLOT_IDX_W'(psa_pkg::SLOT_WORDS - 1))
                        idx_next = '0;
                    else
                        idx_next = idx_reg + psa_pkg::SLOT_IDX_W'(1);
                end
                psa_pkg::PH_DONE:
                begin
                    phase_next = psa_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = psa_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_comb
    begin
        result.valid        = 1'b0;
        result.address      = main_base + psa_pkg::ADDR_W'(offset_reg);
        result.data         = word;
        result.in_remainder = 1'b0;
        result.stream_done  = 1'b0;
        unique case (phase_reg)
            psa_pkg::PH_DATA:
            begin
                result.valid = step;
            end
            psa_pkg::PH_REMAINDER:
            begin
                result.valid        = step;
                result.address      = remainder_base + psa_pkg::ADDR_W'(rem_off);
                result.in_remainder = 1'b1;
                result.stream_done  = is_term && last_slot;
            end
            default:
            begin
                result.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= psa_pkg::PH_OFFSET;
            offset_reg   <= '0;
            left_reg     <= '0;
            slot_reg     <= '0;
            slot_off_reg <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            left_reg     <= left_next;
            slot_reg     <= slot_next;
            slot_off_reg <= slot_off_next;
            idx_reg      <= idx_next;
        end
    end

endmodule

FILE: rtl/core/patch_stream_applier.sv
// Top level of the patch stream applier: input word register, result register, bases.
// Depends on psa_pkg and psa_sequencer.
//
// Takes one patch word per cycle and gives at most one store per word: the word sits
// in an input register, the phase machine and its 64-bit address adds decide the
// store, and the store waits in a result register. A full result register that is
// not taken holds the input register and drops patch_ready; otherwise the rate is
// one word per cycle. The configuration port always accepts; write the bases only
// while no word is in flight.
module patch_stream_applier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             patch_valid,
    output logic                             patch_ready,
    input  logic [psa_pkg::WORD_W-1:0]       patch_word,
    output logic                             write_valid,
    input  logic                             write_ready,
    output logic [psa_pkg::ADDR_W-1:0]       write_address,
    output logic [psa_pkg::WORD_W-1:0]       write_data,
    output logic                             in_remainder,
    output logic                             stream_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psa_pkg::ADDR_W-1:0]       cfg_data
);

    logic [psa_pkg::ADDR_W-1:0]  main_base_reg;
    logic [psa_pkg::ADDR_W-1:0]  rem_base_reg;

    logic                        word_valid_reg, word_valid_next;
    logic [psa_pkg::WORD_W-1:0]  word_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [psa_pkg::ADDR_W-1:0]  addr_reg;
    logic [psa_pkg::WORD_W-1:0]  data_reg;
    logic                        rem_reg;
    logic                        done_reg;

    logic                        advance;
    psa_pkg::psa_result_t        result;

    assign cfg_ready   = 1'b1;
    assign advance     = word_valid_reg && (!out_valid_reg || write_ready);
    assign patch_ready = !word_valid_reg || advance;

    psa_sequencer u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .word           (word_reg),
        .main_base      (main_base_reg),
        .remainder_base (rem_base_reg),
        .result         (result)
    );

    always_comb
    begin
        word_valid_next = word_valid_reg;
        if (patch_valid && patch_ready)
            word_valid_next = 1'b1;
        else if (advance)
            word_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = result.valid;
        else if (write_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_base_reg  <= psa_pkg::MAIN_BASE_RESET;
            rem_base_reg   <= psa_pkg::REMAINDER_BASE_RESET;
            word_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    psa_pkg::CFG_MAIN_BASE:      main_base_reg <= cfg_data;
                    psa_pkg::CFG_REMAINDER_BASE: rem_base_reg  <= cfg_data;
                    default:                     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (patch_valid && patch_ready)
            word_reg <= patch_word;
        if (advance && result.valid)
        begin
            addr_reg <= result.address;
            data_reg <= result.data;
            rem_reg  <= result.in_remainder;
            done_reg <= result.stream_done;
        end
    end

    assign write_valid   = out_valid_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign in_remainder  = rem_reg;
    assign stream_done   = done_reg;

endmodule

FILE: sim/patch_stream_applier_tb.sv
// Self-checking testbench for patch_stream_applier: records, remainder slots and the bases.
// A scoreboard class predicts every store; plain tasks drive the word and register channels.
// Depends on psa_pkg and the patch_stream_applier RTL.
module patch_stream_applier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_MAX        = 11;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int QUIET_LIMIT     = 5000;
    localparam int RECORD_WORDS    = 450;
    localparam int CHUNK_WORDS     = 150;
    localparam int FIRST_SLOT_FILL = 1100;
    localparam int MAX_PRINTED     = 20;

    localparam logic [psa_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = '1;

    class store_predictor;
        psa_pkg::phase_t                phase;
        logic [psa_pkg::WORD_W-1:0]     patch_offset;
        logic [psa_pkg::WORD_W-1:0]     words_left;
        int unsigned                    slot_number;
        int unsigned                    slot_word_index;
        logic [psa_pkg::ADDR_W-1:0]     main_base;
        logic [psa_pkg::ADDR_W-1:0]     remainder_base;
        psa_pkg::psa_result_t           expected_stores[$];
        int unsigned                    mismatch_count;

        function new();
            phase           = psa_pkg::PH_OFFSET;
            patch_offset    = '0;
            words_left      = '0;
            slot_number     = 0;
            slot_word_index = 0;
            main_base       = psa_pkg::MAIN_BASE_RESET;
            remainder_base  = psa_pkg::REMAINDER_BASE_RESET;
            mismatch_count  = 0;
        endfunction

        function int unsigned pending();
            return expected_stores.size();
        endfunction

        function void set_register(input logic [psa_pkg::CFG_INDEX_W-1:0] index,
                                   input logic [psa_pkg::ADDR_W-1:0] value);
            if (index == psa_pkg::CFG_MAIN_BASE)
                main_base = value;
            else if (index == psa_pkg::CFG_REMAINDER_BASE)
                remainder_base = value;
        endfunction

        function void note_word(input logic [psa_pkg::WORD_W-1:0] w);
            psa_pkg::psa_result_t store;
            store       = '0;
            store.valid = 1'b1;
            store.data  = w;
            case (phase)
                psa_pkg::PH_OFFSET:
                begin
                    if (w == psa_pkg::ALL_ONES)
                    begin
                        phase           = psa_pkg::PH_REMAINDER;
                        slot_number     = 0;
                        slot_word_index = 0;
                    end
                    else
                    begin
                        patch_offset = w;
                        phase        = psa_pkg::PH_COUNT;
                    end
                end
                psa_pkg::PH_COUNT:
                begin
                    words_left = w;
                    phase      = (w == '0) ? psa_pkg::PH_OFFSET : psa_pkg::PH_DATA;
                end
                psa_pkg::PH_DATA:
                begin
                    store.address = main_base + psa_pkg::ADDR_W'(patch_offset);
                    expected_stores.push_back(store);
                    patch_offset = patch_offset + psa_pkg::WORD_W'(4);
                    words_left   = words_left - psa_pkg::WORD_W'(1);
                    if (words_left == '0)
                        phase = psa_pkg::PH_OFFSET;
                end
                psa_pkg::PH_REMAINDER:
                begin
                    store.address = remainder_base
                                  + psa_pkg::ADDR_W'(slot_number)
                                  * psa_pkg::ADDR_W'(psa_pkg::SLOT_STRIDE_BYTES)
                                  + psa_pkg::ADDR_W'(slot_word_index) * psa_pkg::ADDR_W'(4);
                    store.in_remainder = 1'b1;
                    if (w == psa_pkg::ALL_ONES)
                    begin
                        slot_number     = slot_number + 1;
                        slot_word_index = 0;
                        if (slot_number >= psa_pkg::SLOT_COUNT)
                        begin
                            store.stream_done = 1'b1;
                            phase             = psa_pkg::PH_DONE;
                        end
                    end
                    else
                    begin
                        slot_word_index = slot_word_index + 1;
                        if (slot_word_index >= psa_pkg::SLOT_WORDS)
                            slot_word_index = 0;
                    end
                    expected_stores.push_back(store);
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(input string what, input logic [psa_pkg::ADDR_W-1:0] got,
                             input logic [psa_pkg::ADDR_W-1:0] want);
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_PRINTED)
                $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        endtask

        task check_store(input logic [psa_pkg::ADDR_W-1:0] address,
                         input logic [psa_pkg::WORD_W-1:0] data,
                         input logic rem, input logic done);
            psa_pkg::psa_result_t want;
            if (expected_stores.size() == 0)
            begin
                report_mismatch("unexpected store", address, '0);
                return;
            end
            want = expected_stores.pop_front();
            if (address !== want.address)
                report_mismatch("write_address", address, want.address);
            if (data !== want.data)
                report_mismatch("write_data", psa_pkg::ADDR_W'(data),
                                psa_pkg::ADDR_W'(want.data));
            if (rem !== want.in_remainder)
                report_mismatch("in_remainder", psa_pkg::ADDR_W'(rem),
                                psa_pkg::ADDR_W'(want.in_remainder));
            if (done !== want.stream_done)
                report_mismatch("stream_done", psa_pkg::ADDR_W'(done),
                                psa_pkg::ADDR_W'(want.stream_done));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic patch_valid;
    logic patch_ready;
    logic [psa_pkg::WORD_W-1:0] patch_word;
    logic write_valid;
    logic write_ready;
    logic [psa_pkg::ADDR_W-1:0] write_address;
    logic [psa_pkg::WORD_W-1:0] write_data;
    logic in_remainder;
    logic stream_done;
    logic cfg_valid;
    logic cfg_ready;
    logic [psa_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [psa_pkg::ADDR_W-1:0] cfg_data;

    store_predictor ledger;
    bit sender_burst   = 1'b0;
    bit receiver_burst = 1'b0;
    bit hold_request   = 1'b0;
    int quiet_cycles   = 0;

    patch_stream_applier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .patch_valid   (patch_valid),
        .patch_ready   (patch_ready),
        .patch_word    (patch_word),
        .write_valid   (write_valid),
        .write_ready   (write_ready),
        .write_address (write_address),
        .write_data    (write_data),
        .in_remainder  (in_remainder),
        .stream_done   (stream_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (write_valid && write_ready)
                ledger.check_store(write_address, write_data, in_remainder, stream_done);
            if (cfg_valid && cfg_ready)
                ledger.set_register(cfg_index, cfg_data);
            if (patch_valid && patch_ready)
                ledger.note_word(patch_word);
        end
    end

    always @(posedge clk)
    begin
        if ((patch_valid && patch_ready) || (write_valid && write_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int stall;
        int unsigned served;
        served = 0;
        write_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                stall = receiver_burst ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall > 0)
            begin
                write_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            write_ready <= 1'b1;
            do @(posedge clk); while (!write_valid);
            served = served + 1;
            if (served % 48 == 0)
                receiver_burst = ($urandom_range(0, 2) == 0);
        end
    end

    // leave valid high after acceptance so a back-to-back word follows with no gap
    task automatic send_word(input logic [psa_pkg::WORD_W-1:0] w);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            patch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        patch_valid <= 1'b1;
        patch_word  <= w;
        do @(posedge clk); while (!patch_ready);
    endtask

    // drop valid, wait for every store, then let in-flight words clear
    task automatic settle();
        patch_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [psa_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [psa_pkg::ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [psa_pkg::ADDR_W-1:0] main_value,
                                  input logic [psa_pkg::ADDR_W-1:0] remainder_value,
                                  input logic [psa_pkg::CFG_INDEX_W-1:0] stray);
        write_register(psa_pkg::CFG_MAIN_BASE, main_value);
        write_register(psa_pkg::CFG_REMAINDER_BASE, remainder_value);
        write_register(stray, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [psa_pkg::ADDR_W-1:0] random_base();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [psa_pkg::CFG_INDEX_W-1:0] stray_index();
        return psa_pkg::CFG_INDEX_W'($urandom_range(int'(psa_pkg::CFG_REMAINDER_BASE) + 1,
                                                    (1 << psa_pkg::CFG_INDEX_W) - 1));
    endfunction

    task automatic random_record(output int unsigned sent);
        logic [psa_pkg::WORD_W-1:0] offset;
        logic [psa_pkg::WORD_W-1:0] data;
        int unsigned count;
        sender_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0)
            offset = psa_pkg::ALL_ONES - psa_pkg::WORD_W'($urandom_range(1, 64));
        else
            offset = $urandom;
        if (offset == psa_pkg::ALL_ONES)
            offset = '0;
        case ($urandom_range(0, 9))
            0: count = 0;
            1: count = $urandom_range(13, 40);
            default: count = $urandom_range(1, 12);
        endcase
        send_word(offset);
        send_word(psa_pkg::WORD_W'(count));
        for (int unsigned i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 15))
                0: data = psa_pkg::ALL_ONES;
                1: data = '0;
                default: data = $urandom;
            endcase
            send_word(data);
        end
        sent = count + 2;
    endtask

    task automatic fill_slot(input int unsigned n);
        logic [psa_pkg::WORD_W-1:0] w;
        for (int unsigned i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 15))
                0: w = '0;
                1: w = psa_pkg::ALL_ONES - psa_pkg::WORD_W'(1);
                default: w = $urandom;
            endcase
            if (w == psa_pkg::ALL_ONES)
                w = '0;
            send_word(w);
            if (i % 32 == 31)
                sender_burst = ($urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned record_total;
        int unsigned chunk;
        ledger = new();
        rst_n       <= 1'b0;
        patch_valid <= 1'b0;
        patch_word  <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= psa_pkg::CFG_MAIN_BASE;
        cfg_data    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(32'h0000_0000);
        send_word(32'd2);
        send_word(32'h0000_0000);
        send_word(psa_pkg::ALL_ONES);
        send_word(32'h1234_5678);
        send_word(32'd0);
        send_word(32'hFFFF_FFF8);
        send_word(32'd3);
        send_word(32'hA5A5_A5A5);
        send_word(32'h5A5A_5A5A);
        send_word(psa_pkg::ALL_ONES);
        settle();
        apply_settings('1, '0, CFG_UNMAPPED);
        send_word(32'h0000_0004);
        send_word(32'd1);
        send_word(32'h8000_0001);
        send_word(32'h7FFF_FFFC);
        send_word(32'd2);
        send_word(psa_pkg::ALL_ONES - 32'd1);
        send_word(32'h0000_0001);
        settle();

        record_total = 0;
        chunk        = 0;
        while (record_total < RECORD_WORDS)
        begin
            random_record(sent);
            record_total = record_total + sent;
            chunk        = chunk + sent;
            if (chunk >= CHUNK_WORDS)
            begin
                chunk = 0;
                settle();
                apply_settings(random_base(), random_base(), stray_index());
            end
        end
        settle();
        apply_settings(random_base(), 64'hFFFF_FFFF_FFFF_F800, stray_index());

        sender_burst = 1'b1;
        hold_request = 1'b1;
        send_word(psa_pkg::ALL_ONES);
        fill_slot(FIRST_SLOT_FILL / 2);
        settle();
        apply_settings(random_base(), '0, stray_index());
        fill_slot(FIRST_SLOT_FILL - FIRST_SLOT_FILL / 2);
        send_word(psa_pkg::ALL_ONES);
        fill_slot(120);
        settle();
        apply_settings(random_base(), random_base(), stray_index());
        send_word(psa_pkg::ALL_ONES);
        fill_slot(20);
        send_word(psa_pkg::ALL_ONES);
        for (int i = 0; i < 10; i++)
            send_word((i % 3 == 0) ? psa_pkg::ALL_ONES : $urandom);
        settle();

        if (ledger.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
